// File: rtl/core/crt_pkg.sv
`timescale 1ns / 1ps
package crt_pkg;

  localparam int MAX_RANGES = 16;
  localparam int PAGE_SHIFT = 16;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [63:0] ALL_ONES = ~64'd0;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] base;
    logic [63:0] size;
    logic        may_write;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] hit_base;
    logic [63:0] hit_end;
    logic        hit_may_write;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] lim;
    logic        wr;
  } entry_t;

endpackage

// File: rtl/core/crt_cell.sv
`timescale 1ns / 1ps
module crt_cell (
  input  logic            clk,
  input  logic            shift,
  input  crt_pkg::entry_t shift_d,
  input  logic            stage_we,
  input  crt_pkg::entry_t stage_d,
  input  logic            commit,
  output crt_pkg::entry_t live
);

  crt_pkg::entry_t live_r;
  crt_pkg::entry_t stage_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      live_r <= stage_r;
    end else if (shift) begin
      live_r <= shift_d;
    end
    if (stage_we) begin
      stage_r <= stage_d;
    end
  end

  assign live = live_r;

endmodule

// File: rtl/core/crt_merge.sv
`timescale 1ns / 1ps
module crt_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic            in_v,
  input  crt_pkg::entry_t in_e,
  input  logic            flush,
  output logic            emit_v,
  output crt_pkg::entry_t emit_e
);

  logic            cv_r;
  crt_pkg::entry_t cur_r;
  logic            mergeable;

  always_comb begin
    mergeable = cv_r && ((in_e.base < cur_r.lim) ||
                         ((in_e.base == cur_r.lim) && (in_e.wr == cur_r.wr)));
    emit_v = cv_r && ((in_v && !mergeable) || flush);
    emit_e = cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (clear || flush) begin
      cv_r <= 1'b0;
    end else if (in_v) begin
      cv_r <= 1'b1;
    end
    if (in_v && !flush && !clear) begin
      if (mergeable) begin
        cur_r <= '{base: cur_r.base,
                   lim: (in_e.lim > cur_r.lim) ? in_e.lim : cur_r.lim,
                   wr: cur_r.wr & in_e.wr};
      end else begin
        cur_r <= in_e;
      end
    end
  end

endmodule

// File: rtl/core/coalescing_range_table_core.sv
`timescale 1ns / 1ps
// sequence: an accepted item passes S_SUM and S_ROUND; empty or wrapped adds and queries
// answered without a walk then go to S_OUT, the others pass S_DECIDE, walk the cell ring
// in S_RUN and, for an add, S_COMMIT before S_OUT
// throughput: one item at a time, set by the full rotation of the cell ring that each walked
// add or query makes; a result register lets the next item in while a result is held off
// reset: synchronous active-low rst_n empties the table and drops any item in flight
module coalescing_range_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output crt_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_ROUND, S_DECIDE, S_RUN, S_COMMIT, S_OUT
  } state_t;

  localparam int N = crt_pkg::MAX_RANGES;
  localparam int CW = crt_pkg::CNT_W;

  state_t state_r;
  logic              mode_r, wr_r, size_zero_r;
  logic [63:0]       base_r, sum_r, lo_r, hi_r;
  logic [CW-1:0]     cnt_r, rot_r, wp_r;
  logic              placed_r, flushed_r, ovf_r, found_r;
  logic              commit_r;
  crt_pkg::out_item_t res_r;
  crt_pkg::out_item_t out_r;
  logic              out_valid_r;
  logic              out_load;

  crt_pkg::entry_t live [N];
  crt_pkg::entry_t head, new_e, feed_e, emit_e;
  logic [N-1:0]    stage_we;
  logic            shift, feeding, take_new, feed_v, flush, emit_v, clear;
  logic            head_ok;

  assign head = live[0];
  assign head_ok = rot_r < cnt_r;
  assign new_e = '{base: lo_r, lim: hi_r, wr: wr_r};

  always_comb begin
    shift = 1'b0;
    take_new = 1'b0;
    feed_v = 1'b0;
    flush = 1'b0;
    feed_e = head;
    feeding = !(placed_r && !head_ok);
    if (state_r == S_RUN) begin
      if (mode_r == crt_pkg::MODE_ADD) begin
        if (feeding) begin
          take_new = !placed_r && (!head_ok || (lo_r < head.base));
          feed_v = 1'b1;
          if (take_new) begin
            feed_e = new_e;
          end
        end else if (!flushed_r) begin
          flush = 1'b1;
        end
      end
      shift = (rot_r != CW'(N)) && !take_new;
    end
  end

  assign clear = state_r == S_DECIDE;

  crt_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .in_v   (feed_v),
    .in_e   (feed_e),
    .flush  (flush),
    .emit_v (emit_v),
    .emit_e (emit_e)
  );

  always_comb begin
    for (int i = 0; i < N; i++) begin
      stage_we[i] = emit_v && (wp_r == CW'(i));
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int NXT = (g + 1) % N;
    crt_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .shift_d  (live[NXT]),
      .stage_we (stage_we[g]),
      .stage_d  (emit_e),
      .commit   (commit_r),
      .live     (live[g])
    );
  end

  // result register is free or drains in this cycle
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      commit_r <= 1'b0;
    end else begin
      commit_r <= (state_r == S_COMMIT) && !ovf_r;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_item.mode;
            wr_r <= in_item.may_write;
            base_r <= in_item.base;
            size_zero_r <= in_item.size == 64'd0;
            sum_r <= in_item.base + in_item.size;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          lo_r <= base_r & ~crt_pkg::PAGE_MASK;
          hi_r <= (sum_r + crt_pkg::PAGE_MASK) & ~crt_pkg::PAGE_MASK;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          rot_r <= '0;
          wp_r <= '0;
          placed_r <= 1'b0;
          flushed_r <= 1'b0;
          ovf_r <= 1'b0;
          found_r <= 1'b0;
          if ((mode_r == crt_pkg::MODE_ADD) && (size_zero_r || (hi_r <= lo_r))) begin
            res_r <= '{hit: 1'b0, hit_base: 64'd0, hit_end: 64'd0, hit_may_write: 1'b0,
                       status: crt_pkg::STATUS_IGNORED};
            state_r <= S_OUT;
          end else if ((mode_r == crt_pkg::MODE_QUERY) && (cnt_r == '0 || size_zero_r)) begin
            res_r <= '0;
            state_r <= S_OUT;
          end else if ((mode_r == crt_pkg::MODE_QUERY) && (hi_r <= lo_r)) begin
            res_r <= '{hit: 1'b1, hit_base: lo_r, hit_end: crt_pkg::ALL_ONES,
                       hit_may_write: 1'b1, status: crt_pkg::STATUS_DONE};
            state_r <= S_OUT;
          end else begin
            res_r <= '0;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (shift) begin
            rot_r <= rot_r + CW'(1);
          end
          if (mode_r == crt_pkg::MODE_ADD) begin
            if (take_new) begin
              placed_r <= 1'b1;
            end
            if (flush) begin
              flushed_r <= 1'b1;
            end
            if (emit_v) begin
              if (wp_r == CW'(N)) begin
                ovf_r <= 1'b1;
              end else begin
                wp_r <= wp_r + CW'(1);
              end
            end
            if (!feeding && flushed_r && rot_r == CW'(N)) begin
              state_r <= S_COMMIT;
            end
          end else begin
            if (head_ok && !found_r && (head.base < hi_r) && (head.lim > lo_r)) begin
              found_r <= 1'b1;
              res_r <= '{hit: 1'b1, hit_base: head.base, hit_end: head.lim,
                         hit_may_write: head.wr, status: crt_pkg::STATUS_DONE};
            end
            if (rot_r == CW'(N)) begin
              state_r <= S_OUT;
            end
          end
        end
        S_COMMIT: begin
          if (ovf_r) begin
            res_r.status <= crt_pkg::STATUS_FULL;
          end else begin
            res_r.status <= crt_pkg::STATUS_DONE;
            cnt_r <= wp_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

// File: dv/crt_checker.sv
`timescale 1ns / 1ps
module crt_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  crt_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  crt_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 n_adds,
  output int                 n_queries,
  output int                 n_hits,
  output int                 n_full
);

  crt_pkg::entry_t    table_q[$];
  crt_pkg::out_item_t expected_q[$];

  function automatic logic [63:0] round_down(logic [63:0] a);
    return a & ~crt_pkg::PAGE_MASK;
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] a);
    return (a + crt_pkg::PAGE_MASK) & ~crt_pkg::PAGE_MASK;
  endfunction

  // merge a new range into the sorted table, returns the status code
  function automatic logic [1:0] merge_range(logic [63:0] lo, logic [63:0] hi, logic wr);
    crt_pkg::entry_t merged[$];
    crt_pkg::entry_t cand[$];
    crt_pkg::entry_t e;
    bit placed;
    placed = 0;
    foreach (table_q[i]) begin
      if (!placed && lo < table_q[i].base) begin
        e.base = lo; e.lim = hi; e.wr = wr;
        cand = {cand, e};
        placed = 1;
      end
      cand = {cand, table_q[i]};
    end
    if (!placed) begin
      e.base = lo; e.lim = hi; e.wr = wr;
      cand = {cand, e};
    end
    foreach (cand[i]) begin
      if (merged.size() > 0 && (cand[i].base < merged[$].lim ||
          (cand[i].base == merged[$].lim && cand[i].wr == merged[$].wr))) begin
        if (cand[i].lim > merged[$].lim) merged[$].lim = cand[i].lim;
        merged[$].wr = merged[$].wr & cand[i].wr;
      end else begin
        merged = {merged, cand[i]};
      end
    end
    if (merged.size() > crt_pkg::MAX_RANGES) return crt_pkg::STATUS_FULL;
    table_q = merged;
    return crt_pkg::STATUS_DONE;
  endfunction

  function automatic crt_pkg::out_item_t predict_result(crt_pkg::in_item_t it);
    crt_pkg::out_item_t r;
    logic [63:0] lo, hi;
    r = '0;
    lo = round_down(it.base);
    hi = round_up(it.base + it.size);
    if (it.mode == crt_pkg::MODE_ADD) begin
      if (it.size == 0 || hi <= lo) r.status = crt_pkg::STATUS_IGNORED;
      else r.status = merge_range(lo, hi, it.may_write);
      return r;
    end
    if (table_q.size() == 0 || it.size == 0) return r;
    if (hi <= lo) begin
      r.hit = 1; r.hit_base = lo; r.hit_end = crt_pkg::ALL_ONES; r.hit_may_write = 1;
      return r;
    end
    foreach (table_q[i]) begin
      if (table_q[i].base < hi && table_q[i].lim > lo) begin
        r.hit = 1;
        r.hit_base = table_q[i].base;
        r.hit_end = table_q[i].lim;
        r.hit_may_write = table_q[i].wr;
        return r;
      end
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    crt_pkg::out_item_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      n_adds <= 0; n_queries <= 0; n_hits <= 0; n_full <= 0;
      table_q.delete();
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        exp_r = predict_result(in_item);
        expected_q = {expected_q, exp_r};
        if (in_item.mode == crt_pkg::MODE_ADD) n_adds <= n_adds + 1;
        else n_queries <= n_queries + 1;
        if (exp_r.hit) n_hits <= n_hits + 1;
        if (exp_r.status == crt_pkg::STATUS_FULL) n_full <= n_full + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.hit !== out_item.hit ||
              exp_r.hit_base !== out_item.hit_base ||
              exp_r.hit_end !== out_item.hit_end ||
              exp_r.hit_may_write !== out_item.hit_may_write ||
              exp_r.status !== out_item.status)
            fail_count <= fail_count + 1;
          if (exp_r.hit !== out_item.hit)
            $error("hit: expected %0h, got %0h", exp_r.hit, out_item.hit);
          if (exp_r.hit_base !== out_item.hit_base)
            $error("hit_base: expected %0h, got %0h", exp_r.hit_base, out_item.hit_base);
          if (exp_r.hit_end !== out_item.hit_end)
            $error("hit_end: expected %0h, got %0h", exp_r.hit_end, out_item.hit_end);
          if (exp_r.hit_may_write !== out_item.hit_may_write)
            $error("hit_may_write: expected %0h, got %0h",
                   exp_r.hit_may_write, out_item.hit_may_write);
          if (exp_r.status !== out_item.status)
            $error("status: expected %0h, got %0h", exp_r.status, out_item.status);
        end
      end
    end
  end
endmodule

// File: dv/coalescing_range_table_core_tb.sv
`timescale 1ns / 1ps
module coalescing_range_table_core_tb;

  localparam int N_RANDOM = 630;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  crt_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 0;
  crt_pkg::out_item_t out_item;
  int                 fail_count, pending, n_adds, n_queries, n_hits, n_full;
  int                 cycle_count = 0;
  bit                 hold_off = 0;
  bit                 phase_quiet = 0;
  int                 rx_wait = 0;

  always #1 clk = ~clk;

  coalescing_range_table_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  crt_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending), .n_adds(n_adds),
    .n_queries(n_queries), .n_hits(n_hits), .n_full(n_full)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coalescing_range_table_core_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // addresses mostly clustered in a small window so ranges overlap and touch often
  function automatic crt_pkg::in_item_t random_item();
    crt_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.mode = ($urandom_range(0, 99) < 45) ? crt_pkg::MODE_ADD : crt_pkg::MODE_QUERY;
    it.may_write = 1'($urandom_range(0, 1));
    if (sel < 80) begin
      it.base = 64'h7000_0000 + ({32'd0, $urandom_range(0, 63)} << crt_pkg::PAGE_SHIFT)
                + $urandom_range(0, 3) * $urandom;
      it.size = ({32'd0, $urandom_range(0, 6)} << crt_pkg::PAGE_SHIFT)
                + $urandom_range(0, 1) * $urandom_range(0, 65535);
    end else if (sel < 90) begin
      it.base = rand64();
      it.size = rand64();
    end else begin
      it.base = ~64'd0 - {32'd0, $urandom_range(0, 3)} * $urandom;
      it.size = $urandom_range(0, 1) ? rand64() : {32'd0, $urandom};
    end
    return it;
  endfunction

  // present the item until accepted, then idle for a drawn number of cycles
  task automatic send(crt_pkg::in_item_t it);
    int gap;
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_fields(logic m, logic [63:0] b, logic [63:0] s, logic w);
    crt_pkg::in_item_t it;
    it.mode = m; it.base = b; it.size = s; it.may_write = w;
    send(it);
  endtask

  // receiver: drawn wait per result, plus one long hold-off on request
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall <= 0;
      rx_wait <= 0;
    end else if (hold_off) begin
      out_stall <= 1;
    end else if (phase_quiet) begin
      out_stall <= 0;
      rx_wait <= 0;
    end else if (out_valid && !out_stall) begin
      draw = $urandom_range(0, 15);
      rx_wait <= draw;
      out_stall <= (draw != 0);
    end else if (out_valid && rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else begin
      out_stall <= (rx_wait != 0);
    end
  end

  initial begin
    int unsigned pg;
    pg = 1 << crt_pkg::PAGE_SHIFT;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send_fields(crt_pkg::MODE_QUERY, 64'h1000, 64'h1000, 1'b0);
    send_fields(crt_pkg::MODE_QUERY, ~64'd0, ~64'd0, 1'b1);
    send_fields(crt_pkg::MODE_ADD, 64'h1_0000, 64'd0, 1'b1);
    send_fields(crt_pkg::MODE_ADD, ~64'd0 - 5, 64'd100, 1'b1);
    send_fields(crt_pkg::MODE_ADD, 64'h10_0000, pg, 1'b1);
    send_fields(crt_pkg::MODE_ADD, 64'h10_0000 + pg, pg, 1'b1);
    send_fields(crt_pkg::MODE_ADD, 64'h10_0000 + 2 * pg, pg, 1'b0);
    send_fields(crt_pkg::MODE_ADD, 64'h10_0000 + 64'h8000, pg, 1'b1);
    send_fields(crt_pkg::MODE_QUERY, 64'h10_0000, 64'd1, 1'b0);
    send_fields(crt_pkg::MODE_QUERY, 64'h10_0000 + 2 * pg + 5, 64'd3, 1'b0);
    send_fields(crt_pkg::MODE_QUERY, 64'h0, 64'h10_0000, 1'b1);
    send_fields(crt_pkg::MODE_QUERY, 64'h0, 64'd0, 1'b1);
    send_fields(crt_pkg::MODE_QUERY, ~64'd0 - 5, 64'd100, 1'b0);
    send_fields(crt_pkg::MODE_ADD, 64'd0, pg, 1'b1);
    send_fields(crt_pkg::MODE_ADD, 64'hFFFF_FFFF_FFFE_0000, 64'h1_0000, 1'b1);
    send_fields(crt_pkg::MODE_QUERY, 64'hFFFF_FFFF_FFFF_0000, 64'h1, 1'b0);
    // fill the table with separated ranges to reach the full case
    for (int i = 0; i < 18; i++)
      send_fields(crt_pkg::MODE_ADD, 64'h4000_0000 + i * 4 * pg, pg, i[0]);
    send_fields(crt_pkg::MODE_QUERY, 64'h4000_0000, 64'h100_0000, 1'b0);
    // sender pause until drained, then collapse most of the table by a reset-free merge
    idle_input();
    wait (pending == 0);
    send_fields(crt_pkg::MODE_ADD, 64'h0, 64'hFFFF_FFFF_0000_0000, 1'b0);
    send_fields(crt_pkg::MODE_QUERY, 64'h5000, 64'h10, 1'b0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send(random_item());
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 149) begin
        idle_input();
        wait (pending == 0);
        repeat (30) @(posedge clk);
      end
      phase_quiet = (i % 200) < 30;
      send(random_item());
    end
    phase_quiet = 0;

    idle_input();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d adds (%0d hit a full table) and %0d queries (%0d hits)",
             n_adds, n_full, n_queries, n_hits);
    if (fail_count == 0)
      $display("coalescing_range_table_core_tb: done, clean");
    else
      $display("coalescing_range_table_core_tb: done, errors");
    $finish;
  end
endmodule

// File: files.f
rtl/core/crt_pkg.sv
rtl/core/crt_cell.sv
rtl/core/crt_merge.sv
rtl/core/coalescing_range_table_core.sv
dv/crt_checker.sv
dv/coalescing_range_table_core_tb.sv
